/* design/assert_macros.svh */
// Assertion macros used by the ordered list top module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

/* design/olasd_pkg.sv */
// Shared types and constants for the ordered list block.
package olasd_pkg;

    localparam int DEPTH   = 16;
    localparam int WORD_W  = 64;
    localparam int POS_W   = 8;
    localparam int INDEX_W = 6;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        ACT_APPEND  = 2'd0,
        ACT_SEARCH  = 2'd1,
        ACT_DELETE  = 2'd2,
        ACT_DISPLAY = 2'd3
    } action_t;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_RANGE     = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    // per-cell control: load the new word, or take the neighbor's word
    typedef struct packed {
        logic wr;
        logic take;
    } cell_ctl_t;

endpackage

/* design/olasd_cell.sv */
// One storage cell of the list chain: holds a word, loads or takes its neighbor's.
module olasd_cell (
    input  logic                          clk,
    input  olasd_pkg::cell_ctl_t          ctl,
    input  logic [olasd_pkg::WORD_W-1:0]  wr_data,
    input  logic [olasd_pkg::WORD_W-1:0]  nbr_data,
    output logic [olasd_pkg::WORD_W-1:0]  data
);

    logic [olasd_pkg::WORD_W-1:0] data_reg;
    logic [olasd_pkg::WORD_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (ctl.wr)
        begin
            data_next = wr_data;
        end
        else if (ctl.take)
        begin
            data_next = nbr_data;
        end
    end

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

/* design/ordered_list_append_search_delete.sv */
// Ordered list of up to DEPTH 64-bit words kept in a chain of cells, cell 0 at the head.
// Append writes the tail cell and delete shifts the cells at and above the position down by
// one, both in the cycle the word is taken. Their one result word then loads into the output
// register from the response state once that register is free. Search and display rotate the
// whole ring one cell per cycle past the head, a display holding while the output register
// cannot take an entry. A search then loads its result word from the response state. A display
// gives one word per stored entry with last set on the final one, and gives nothing for an
// empty list. Every action also waits while the output side leaves a result word unread and
// the next one is due. A new input word is taken whenever the sequencer is idle, even while a
// result word still sits in the output register. Matching compares raw bit patterns.
`include "assert_macros.svh"

module ordered_list_append_search_delete (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [1:0]                      action,
    input  logic [olasd_pkg::WORD_W-1:0]    value,
    input  logic [olasd_pkg::POS_W-1:0]     position,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [1:0]                      status,
    output logic [olasd_pkg::INDEX_W-1:0]   index,
    output logic [olasd_pkg::WORD_W-1:0]    entry_value,
    output logic                            last
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_RESP = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [olasd_pkg::CNT_W-1:0]   count_reg, count_next;
    logic [olasd_pkg::IDX_W-1:0]   step_reg, step_next;
    logic                          display_reg, display_next;
    logic                          found_reg, found_next;
    logic [olasd_pkg::IDX_W-1:0]   found_idx_reg, found_idx_next;
    logic [olasd_pkg::WORD_W-1:0]  key_reg, key_next;
    logic [1:0]                    pend_status_reg, pend_status_next;
    logic [olasd_pkg::INDEX_W-1:0] pend_index_reg, pend_index_next;

    logic                          out_valid_reg, out_valid_next;
    logic [1:0]                    status_reg, status_next;
    logic [olasd_pkg::INDEX_W-1:0] index_reg, index_next;
    logic [olasd_pkg::WORD_W-1:0]  entry_value_reg, entry_value_next;
    logic                          last_reg, last_next;

    olasd_pkg::cell_ctl_t         ctl [olasd_pkg::DEPTH];
    logic [olasd_pkg::WORD_W-1:0] cell_data [olasd_pkg::DEPTH];

    logic in_acc;
    logic slot_free;
    logic in_range;
    logic last_step;
    logic advance;
    logic emit;
    logic match_now;
    logic full;
    logic del_ok;
    olasd_pkg::action_t act;

    // ---------------------------------------------------------------- cell chain
    // Each cell takes the word of the cell above it; the top cell wraps to the head so a
    // full DEPTH-step rotation restores the original order.
    for (genvar i = 0; i < olasd_pkg::DEPTH; i++)
    begin : g_cell
        localparam int NX = (i + 1) % olasd_pkg::DEPTH;
        olasd_cell u_cell (
            .clk      (clk),
            .ctl      (ctl[i]),
            .wr_data  (value),
            .nbr_data (cell_data[NX]),
            .data     (cell_data[i])
        );
    end

    // ---------------------------------------------------------------- status terms
    assign in_ready  = (state_reg == S_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign act       = olasd_pkg::action_t'(action);
    assign slot_free = !out_valid_reg || out_ready;
    assign full      = (count_reg == olasd_pkg::CNT_W'(olasd_pkg::DEPTH));
    assign del_ok    = (olasd_pkg::POS_W'(count_reg) > position);
    assign in_range  = (olasd_pkg::CNT_W'(step_reg) < count_reg);
    assign last_step = (step_reg == olasd_pkg::IDX_W'(olasd_pkg::DEPTH - 1));
    // a displayed entry may only move on once the output register can take it
    assign emit      = (state_reg == S_SCAN) && display_reg && in_range && slot_free;
    assign advance   = (state_reg == S_SCAN) && (!(display_reg && in_range) || slot_free);
    assign match_now = in_range && (cell_data[0] == key_reg);

    // ---------------------------------------------------------------- cell control
    always_comb
    begin
        for (int i = 0; i < olasd_pkg::DEPTH; i++)
        begin
            ctl[i].wr   = in_acc && (act == olasd_pkg::ACT_APPEND) && !full
                          && (count_reg[olasd_pkg::IDX_W-1:0] == olasd_pkg::IDX_W'(i));
            // delete closes the gap; the top cell keeps a stale word beyond count
            ctl[i].take = advance
                          || (in_acc && (act == olasd_pkg::ACT_DELETE) && del_ok
                              && (olasd_pkg::POS_W'(i) >= position)
                              && (i < olasd_pkg::DEPTH - 1));
        end
    end

    // ---------------------------------------------------------------- sequencer
    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        step_next        = step_reg;
        display_next     = display_reg;
        found_next       = found_reg;
        found_idx_next   = found_idx_reg;
        key_next         = key_reg;
        pend_status_next = pend_status_reg;
        pend_index_next  = pend_index_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    pend_index_next = '0;
                    step_next       = '0;
                    found_next      = 1'b0;
                    found_idx_next  = '0;
                    key_next        = value;
                    case (act)
                        olasd_pkg::ACT_APPEND:
                        begin
                            if (full)
                            begin
                                pend_status_next = olasd_pkg::ST_FULL;
                            end
                            else
                            begin
                                pend_status_next = olasd_pkg::ST_OK;
                                count_next       = count_reg + 1'b1;
                            end
                            state_next = S_RESP;
                        end
                        olasd_pkg::ACT_SEARCH:
                        begin
                            display_next = 1'b0;
                            state_next   = S_SCAN;
                        end
                        olasd_pkg::ACT_DELETE:
                        begin
                            if (del_ok)
                            begin
                                pend_status_next = olasd_pkg::ST_OK;
                                count_next       = count_reg - 1'b1;
                            end
                            else
                            begin
                                pend_status_next = olasd_pkg::ST_RANGE;
                            end
                            state_next = S_RESP;
                        end
                        default:
                        begin
                            // display of an empty list gives no result
                            display_next = 1'b1;
                            state_next   = (count_reg == '0) ? S_IDLE : S_SCAN;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (advance)
                begin
                    step_next = step_reg + 1'b1;
                    if (!display_reg && !found_reg && match_now)
                    begin
                        found_next     = 1'b1;
                        found_idx_next = step_reg;
                    end
                    if (last_step)
                    begin
                        step_next = '0;
                        if (display_reg)
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            if (found_reg)
                            begin
                                pend_status_next = olasd_pkg::ST_OK;
                                pend_index_next  = olasd_pkg::INDEX_W'(found_idx_reg);
                            end
                            else if (match_now)
                            begin
                                pend_status_next = olasd_pkg::ST_OK;
                                pend_index_next  = olasd_pkg::INDEX_W'(step_reg);
                            end
                            else
                            begin
                                pend_status_next = olasd_pkg::ST_NOT_FOUND;
                                pend_index_next  = '0;
                            end
                            state_next = S_RESP;
                        end
                    end
                end
            end
            S_RESP:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------- output register
    always_comb
    begin
        out_valid_next   = out_valid_reg;
        status_next      = status_reg;
        index_next       = index_reg;
        entry_value_next = entry_value_reg;
        last_next        = last_reg;

        if (emit)
        begin
            out_valid_next   = 1'b1;
            status_next      = olasd_pkg::ST_OK;
            index_next       = olasd_pkg::INDEX_W'(step_reg);
            entry_value_next = cell_data[0];
            last_next        = (olasd_pkg::CNT_W'(step_reg) + 1'b1 == count_reg);
        end
        else if ((state_reg == S_RESP) && slot_free)
        begin
            out_valid_next   = 1'b1;
            status_next      = pend_status_reg;
            index_next       = pend_index_reg;
            entry_value_next = '0;
            last_next        = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            step_reg      <= '0;
            display_reg   <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            step_reg      <= step_next;
            display_reg   <= display_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        found_idx_reg   <= found_idx_next;
        key_reg         <= key_next;
        pend_status_reg <= pend_status_next;
        pend_index_reg  <= pend_index_next;
        status_reg      <= status_next;
        index_reg       <= index_next;
        entry_value_reg <= entry_value_next;
        last_reg        <= last_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign index       = index_reg;
    assign entry_value = entry_value_reg;
    assign last        = last_reg;

    // ---------------------------------------------------------------- assertions
    `ASSERT_IMPLY(a_count_bound, clk, rst_n, 1'b1,
                  count_reg <= olasd_pkg::CNT_W'(olasd_pkg::DEPTH))
    `ASSERT_IMPLY(a_mid_is_display, clk, rst_n, out_valid_reg && !last_reg,
                  status_reg == olasd_pkg::ST_OK)
    `ASSERT_NEXT(a_scan_keeps_count, clk, rst_n, state_reg == S_SCAN,
                 count_reg == $past(count_reg))

endmodule
